// ===== rtl/core/binary_heap_priority_queue_top_assert.svh =====
// Assertion macros for the binary heap priority queue checker.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BHPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bhpq assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define BHPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bhpq assertion failed");

`endif

// ===== rtl/core/bhpq_pkg.sv =====
// Shared constants, types and compare function for the binary heap priority queue.
package bhpq_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CHILD_W     = ADDR_W + 2;
  localparam int KEY_W       = 32;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int SIZE_W      = 8;
  localparam int CAP_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int OUT_DATA_W  = 2 * KEY_W + SIZE_W;

  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXTRACT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INFO    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    key_t              key;
  } req_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    key_t                key_out;
    logic [SIZE_W-1:0]   size_now;
    key_t                last_key;
  } res_t;

  function automatic logic above(input key_t a, input key_t b, input logic max_order);
    above = max_order ? (a > b) : (a < b);
  endfunction

endpackage

// ===== rtl/core/binary_heap_priority_queue_top.sv =====
// Top level of the binary heap priority queue: stream ports, registers, result register.
// One request at a time is held in a 128-entry heap RAM with registered read.
// Info reads the root; a full or empty request goes straight to the result. Insert
// climbs the heap by reading each parent and comparing; extract descends by reading
// the left and then the right child and comparing, in turn over the single RAM read
// port. Writing either register empties the heap and clears the last inserted key;
// a finished result waits in the output register.
module binary_heap_priority_queue_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bhpq_pkg::KEY_W-1:0]          s_tdata,   // key_in[31:0]
  input  logic [bhpq_pkg::MODE_W-1:0]         s_tuser,   // mode[1:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bhpq_pkg::OUT_DATA_W-1:0]     m_tdata,   // key_out[31:0], size_now[39:32],
                                                         // last_key[71:40]
  output logic [bhpq_pkg::STATUS_W-1:0]       m_tuser,   // status[1:0]
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bhpq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bhpq_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bhpq_pkg::*;

  logic             heap_order;
  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] cap_lim;
  logic             clear;
  logic             idle;
  logic             take;
  req_t             req;
  res_t             res;

  assign cfg_ready = 1'b1;
  assign s_tready  = idle;
  assign take      = !m_tvalid || m_tready;
  assign req.mode  = s_tuser;
  assign req.key   = key_t'(s_tdata);

  always_comb begin
    if (capacity == '0) begin
      cap_lim = CNT_W'(1);
    end else if (int'(capacity) > MAX_ENTRIES) begin
      cap_lim = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_lim = CNT_W'(capacity);
    end
  end

  always_comb begin
    clear = 1'b0;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORDER, CFG_CAPACITY: clear = 1'b1;
        default:                 clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_order <= 1'b0;
      capacity   <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORDER:    heap_order <= cfg_data[0];
        CFG_CAPACITY: capacity   <= CAP_W'(cfg_data);
        default: ;
      endcase
    end
  end

  bhpq_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid && s_tready),
    .req       (req),
    .max_order (heap_order),
    .cap_lim   (cap_lim),
    .clear     (clear),
    .take      (take),
    .idle      (idle),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= res.valid;
      if (res.valid) begin
        m_tuser <= res.status;
        m_tdata <= {res.last_key, res.size_now, res.key_out};
      end
    end
  end

endmodule

// ===== rtl/core/bhpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bhpq_engine.sv =====
// Heap sequencer: insert with sift-up, extract with sift-down, info, over one RAM.
module bhpq_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  bhpq_pkg::req_t          req,
  input  logic                    max_order,
  input  logic [bhpq_pkg::CNT_W-1:0] cap_lim,
  input  logic                    clear,
  input  logic                    take,
  output logic                    idle,
  output bhpq_pkg::res_t          res
);
  import bhpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_EXT_LAST, S_EXT_LOAD,
    S_SD_L, S_SD_R, S_SD_CMP, S_INFO, S_FIN
  } state_t;

  state_t              st;
  logic [ADDR_W-1:0]   pos;
  key_t                key;
  key_t                lval;
  logic                lwin;
  logic [CNT_W-1:0]    count;
  key_t                recent;
  logic [STATUS_W-1:0] status;
  key_t                kout;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  key_t                wdata;
  logic [ADDR_W-1:0]   raddr;
  logic [KEY_W-1:0]    rdata_raw;
  key_t                rdata;

  logic [ADDR_W-1:0]   parent;
  logic [CHILD_W-1:0]  lidx;
  logic [CHILD_W-1:0]  ridx;
  logic [CHILD_W-1:0]  cnt_ext;
  logic                has_l;
  logic                has_r;
  key_t                best;
  logic                take_r;
  logic                ins_up;

  bhpq_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata   = key_t'(rdata_raw);
  assign parent  = ADDR_W'((pos - 1'b1) >> 1);
  assign lidx    = CHILD_W'({pos, 1'b1});
  assign ridx    = lidx + 1'b1;
  assign cnt_ext = CHILD_W'(count);
  assign has_l   = lidx < cnt_ext;
  assign has_r   = ridx < cnt_ext;
  assign best    = lwin ? lval : key;
  assign take_r  = has_r && above(rdata, best, max_order);
  assign ins_up  = above(key, rdata, max_order);

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = key;
    raddr = '0;
    unique case (st)
      S_INS_RD: begin
        if (pos == '0) begin
          we = 1'b1;
        end else begin
          raddr = parent;
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (ins_up) begin
          wdata = rdata;
        end
      end
      S_EXT_LAST: raddr = count[ADDR_W-1:0];
      S_SD_L: begin
        if (!has_l) begin
          we = 1'b1;
        end else begin
          raddr = lidx[ADDR_W-1:0];
        end
      end
      S_SD_R: raddr = ridx[ADDR_W-1:0];
      S_SD_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wdata = rdata;
        end else if (lwin) begin
          wdata = lval;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_IDLE;
      count  <= '0;
      recent <= '0;
    end else begin
      if (clear) begin
        count  <= '0;
        recent <= '0;
      end
      unique case (st)
        S_IDLE: begin
          if (start) begin
            status <= ST_OK;
            kout   <= '0;
            unique case (req.mode)
              MODE_INSERT: begin
                if (count >= cap_lim) begin
                  status <= ST_FULL;
                  st     <= S_FIN;
                end else begin
                  pos    <= count[ADDR_W-1:0];
                  key    <= req.key;
                  recent <= req.key;
                  count  <= count + 1'b1;
                  st     <= S_INS_RD;
                end
              end
              MODE_EXTRACT: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                  st     <= S_FIN;
                end else begin
                  count <= count - 1'b1;
                  st    <= S_EXT_LAST;
                end
              end
              MODE_INFO: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                  st     <= S_FIN;
                end else begin
                  st <= S_INFO;
                end
              end
              default: st <= S_FIN;
            endcase
          end
        end
        S_INS_RD: st <= (pos == '0) ? S_FIN : S_INS_CMP;
        S_INS_CMP: begin
          if (ins_up) begin
            pos <= parent;
            st  <= S_INS_RD;
          end else begin
            st <= S_FIN;
          end
        end
        S_EXT_LAST: begin
          kout <= rdata;
          st   <= S_EXT_LOAD;
        end
        S_EXT_LOAD: begin
          key <= rdata;
          pos <= '0;
          st  <= S_SD_L;
        end
        S_SD_L: st <= has_l ? S_SD_R : S_FIN;
        S_SD_R: begin
          lval <= rdata;
          lwin <= above(rdata, key, max_order);
          st   <= S_SD_CMP;
        end
        S_SD_CMP: begin
          if (take_r) begin
            pos <= ridx[ADDR_W-1:0];
            st  <= S_SD_L;
          end else if (lwin) begin
            pos <= lidx[ADDR_W-1:0];
            st  <= S_SD_L;
          end else begin
            st <= S_FIN;
          end
        end
        S_INFO: begin
          kout <= rdata;
          st   <= S_FIN;
        end
        S_FIN: begin
          if (take) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign idle         = (st == S_IDLE);
  assign res.valid    = (st == S_FIN);
  assign res.status   = status;
  assign res.key_out  = kout;
  assign res.size_now = SIZE_W'(count);
  assign res.last_key = recent;

endmodule

// ===== rtl/core/bhpq_checker.sv =====
// Port-level checker for the binary heap priority queue, bound to the top level.
`include "binary_heap_priority_queue_top_assert.svh"

module bhpq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [bhpq_pkg::OUT_DATA_W-1:0]     m_tdata,
  input logic [bhpq_pkg::STATUS_W-1:0]       m_tuser
);
  import bhpq_pkg::*;

  `BHPQ_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
  `BHPQ_ASSERT_NOW(a_size_bound, m_tvalid,
    int'(m_tdata[KEY_W+SIZE_W-1:KEY_W]) <= MAX_ENTRIES)
  `BHPQ_ASSERT_NOW(a_empty_result, m_tvalid && m_tuser == ST_EMPTY,
    m_tdata[KEY_W+SIZE_W-1:KEY_W] == '0 && m_tdata[KEY_W-1:0] == '0)
  `BHPQ_ASSERT_NOW(a_full_result, m_tvalid && m_tuser == ST_FULL,
    m_tdata[KEY_W-1:0] == '0 && m_tdata[KEY_W+SIZE_W-1:KEY_W] != '0)
  `BHPQ_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind binary_heap_priority_queue_top bhpq_checker u_bhpq_checker (.*);

// ===== bench/binary_heap_priority_queue_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the binary heap priority queue: directed and random requests.
module binary_heap_priority_queue_top_tb;
  import bhpq_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_NOP     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int IDLE_PCT    = 17;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 120;
  localparam key_t KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam key_t KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    key_t                key_out;
    logic [SIZE_W-1:0]   size_now;
    key_t                last_key;
  } heap_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [KEY_W-1:0]      s_tdata = '0;
  logic [MODE_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  key_t             heap_keys [MAX_ENTRIES];
  int unsigned      heap_count = 0;
  key_t             newest_key = '0;
  logic             max_order = 1'b0;
  logic [CAP_W-1:0] cap_reg = CAP_RESET;

  heap_reply_t replies_due [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  binary_heap_priority_queue_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit outranks(input key_t a, input key_t b);
    return max_order ? (a > b) : (a < b);
  endfunction

  function automatic int unsigned heap_limit();
    if (cap_reg == 0) return 1;
    if (cap_reg > MAX_ENTRIES) return MAX_ENTRIES;
    return 32'(cap_reg);
  endfunction

  function automatic void swap_keys(input int unsigned i, input int unsigned j);
    key_t t;
    t = heap_keys[i];
    heap_keys[i] = heap_keys[j];
    heap_keys[j] = t;
  endfunction

  function automatic heap_reply_t predict_heap_op(input logic [MODE_W-1:0] mode,
                                                  input key_t key);
    heap_reply_t r;
    int unsigned pos;
    int unsigned up;
    int unsigned best;
    int unsigned child;
    r.status = ST_OK;
    r.key_out = '0;
    case (mode)
      MODE_INSERT: begin
        if (heap_count >= heap_limit()) begin
          r.status = ST_FULL;
        end else begin
          heap_keys[heap_count] = key;
          pos = heap_count;
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (!outranks(heap_keys[pos], heap_keys[up])) break;
            swap_keys(pos, up);
            pos = up;
          end
          heap_count++;
          newest_key = key;
        end
      end
      MODE_EXTRACT: begin
        if (heap_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.key_out = heap_keys[0];
          heap_keys[0] = heap_keys[heap_count - 1];
          heap_count--;
          pos = 0;
          while (1'b1) begin
            best = pos;
            child = 2 * pos + 1;
            if (child < heap_count && outranks(heap_keys[child], heap_keys[best])) best = child;
            child = 2 * pos + 2;
            if (child < heap_count && outranks(heap_keys[child], heap_keys[best])) best = child;
            if (best == pos) break;
            swap_keys(pos, best);
            pos = best;
          end
        end
      end
      MODE_INFO: begin
        if (heap_count == 0) r.status = ST_EMPTY;
        else r.key_out = heap_keys[0];
      end
      default: begin
      end
    endcase
    r.size_now = heap_count[SIZE_W-1:0];
    r.last_key = newest_key;
    return r;
  endfunction

  function automatic key_t random_key();
    case ($urandom_range(9))
      0: return key_t'(int'($urandom_range(6)) - 3);
      1: return $urandom_range(1) ? KEY_MIN : KEY_MAX;
      default: return key_t'($urandom);
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(input int unsigned insert_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < insert_pct) return MODE_INSERT;
    if (r < 92) return MODE_EXTRACT;
    if (r < 97) return MODE_INFO;
    return MODE_NOP;
  endfunction

  task automatic report_mismatch(input string what, input heap_reply_t want,
                                 input heap_reply_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected status %0d key %0d size %0d last %0d,",
               $realtime, what, want.status, want.key_out, want.size_now, want.last_key);
      $display("    got status %0d key %0d size %0d last %0d",
               got.status, got.key_out, got.size_now, got.last_key);
    end
  endtask

  task automatic send_request(input logic [MODE_W-1:0] mode, input key_t key);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= key;
    s_tuser <= mode;
    do @(posedge clk); while (!s_tready);
    replies_due.push_back(predict_heap_op(mode, key));
  endtask

  task automatic drain_replies();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
    case (idx)
      CFG_ORDER: begin
        max_order = data[0];
        heap_count = 0;
        newest_key = '0;
      end
      CFG_CAPACITY: begin
        cap_reg = data;
        heap_count = 0;
        newest_key = '0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_heap_config(input logic [CFG_DATA_W-1:0] order_data,
                                 input logic [CFG_DATA_W-1:0] cap);
    drain_replies();
    write_register(CFG_ORDER, order_data, 1'b1);
    write_register(CFG_CAPACITY, cap, 1'b0);
  endtask

  task automatic test_defaults();
    send_request(MODE_INFO, KEY_MAX);
    send_request(MODE_EXTRACT, KEY_MIN);
    send_request(MODE_NOP, 32'sd5);
    send_request(MODE_INSERT, KEY_MAX);
    send_request(MODE_INSERT, KEY_MIN);
    send_request(MODE_INSERT, 32'sd0);
    send_request(MODE_INSERT, -32'sd1);
    send_request(MODE_INSERT, 32'sd1);
    send_request(MODE_NOP, -32'sd1);
    send_request(MODE_INFO, 32'sd0);
    repeat (5) send_request(MODE_EXTRACT, random_key());
    send_request(MODE_EXTRACT, random_key());
  endtask

  task automatic test_registers();
    // max order, single slot: full on the second insert
    set_heap_config(8'h01, 8'd1);
    send_request(MODE_INSERT, 32'sd5);
    send_request(MODE_INSERT, 32'sd6);
    send_request(MODE_INFO, 32'sd0);
    send_request(MODE_EXTRACT, 32'sd0);
    send_request(MODE_EXTRACT, 32'sd0);
    // zero capacity acts as one slot
    drain_replies();
    write_register(CFG_CAPACITY, 8'd0, 1'b0);
    send_request(MODE_INSERT, KEY_MIN);
    send_request(MODE_INSERT, KEY_MAX);
    // spare indexes leave the heap alone
    drain_replies();
    write_register(CFG_SPARE_HI, 8'hff, 1'b1);
    write_register(CFG_SPARE_LO, 8'h5a, 1'b0);
    send_request(MODE_INFO, 32'sd0);
  endtask

  task automatic test_fill_and_drain();
    set_heap_config(8'($urandom_range(255)), 8'd255);
    calm = 1'b1;
    repeat (MAX_ENTRIES + 4) send_request(MODE_INSERT, random_key());
    repeat (4) send_request(MODE_INFO, random_key());
    repeat (MAX_ENTRIES + 6) send_request(MODE_EXTRACT, random_key());
    calm = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] cap;
    int unsigned insert_pct;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(9))
        0: cap = 8'd0;
        1: cap = 8'd1;
        2: cap = 8'd2;
        3: cap = 8'd3;
        4: cap = 8'($urandom_range(127, 4));
        5: cap = 8'($urandom_range(255, 129));
        default: cap = CAP_RESET;
      endcase
      set_heap_config(8'($urandom_range(255)), cap);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        insert_pct = (n < PHASE_ITEMS * 6 / 10) ? 70 : 20;
        if (n == PHASE_ITEMS / 2 && p == 0) drain_replies();
        send_request(pick_mode(insert_pct), random_key());
      end
    end
  endtask

  always @(posedge clk) begin : reply_check
    heap_reply_t got;
    heap_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser;
      got.key_out = m_tdata[31:0];
      got.size_now = m_tdata[39:32];
      got.last_key = m_tdata[71:40];
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected reply", '0, got);
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status || got.key_out !== want.key_out ||
            got.size_now !== want.size_now || got.last_key !== want.last_key)
          report_mismatch("reply mismatch", want, got);
      end
    end
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_registers();
    test_fill_and_drain();
    test_random_phases();
    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
